// ===== sv/rca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring chunk allocator package
// Shared widths, constants, status codes and transaction types.
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam int RING_BYTES   = 4096;
  localparam int PREFIX_BYTES = 4;

  localparam int TABLE_DEPTH = RING_BYTES + 1;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = 13;
  localparam int REQ_W       = 13;
  localparam int NEED_W      = REQ_W + 1;
  localparam int SUM_W       = ADDR_W + 2;
  localparam int EVICT_W     = 11;
  localparam int GUARD_LIMIT = 2 * RING_BYTES + 8;
  localparam int GUARD_W     = $clog2(GUARD_LIMIT + 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_GRANTED  = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_FREED    = 2'd2;
  localparam logic [1:0] ST_NOTHING  = 2'd3;

  typedef struct packed {
    logic             action;
    logic [REQ_W-1:0] request_bytes;
  } rca_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  payload_offset;
    logic [EVICT_W-1:0] evicted_count;
    logic               is_wrapped;
  } rca_out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  data;
  } rca_wr_t;

endpackage

// ===== sv/rca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rca_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// One-entry output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module rca_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rca_pkg::rca_out_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output rca_pkg::rca_out_t out_data
);

  import rca_pkg::*;

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= push_data;
    end
  end

endmodule

// ===== sv/rca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator sequencer
// Holds head, tail and wrap state and walks the length table through
// read-modify-write steps for allocate, evict and free transactions.
// ----------------------------------------------------------------------------
module rca_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rca_pkg::ADDR_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rca_pkg::rca_in_t           in_data,
  output logic                       res_push,
  output rca_pkg::rca_out_t          res_data,
  input  logic                       res_room,
  output rca_pkg::rca_wr_t           mem_wr,
  output logic [rca_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [rca_pkg::LEN_W-1:0]  mem_rdata
);

  import rca_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_ITER,
    S_REL_RD,
    S_REL_CHK,
    S_PLACE,
    S_FINISH
  } state_t;

  localparam logic [ADDR_W-1:0]  RING_A     = ADDR_W'(RING_BYTES);
  localparam logic [ADDR_W-1:0]  CLEAR_LAST = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [GUARD_W-1:0] GUARD_END  = GUARD_W'(GUARD_LIMIT);

  state_t              state;
  logic [ADDR_W-1:0]   ring_size;
  logic [ADDR_W-1:0]   head;
  logic [ADDR_W-1:0]   tail;
  logic                wrap;
  logic [ADDR_W-1:0]   clr_addr;
  logic                place_pending;
  logic                action;
  logic [REQ_W-1:0]    req;
  logic [GUARD_W-1:0]  guard;
  logic [EVICT_W-1:0]  evicted;
  logic [1:0]          res_status;
  logic [ADDR_W-1:0]   res_offset;

  logic [ADDR_W-1:0]   size_eff;
  logic [NEED_W-1:0]   need;
  logic [SUM_W-1:0]    tail_need;
  logic [SUM_W-1:0]    head_adv;
  logic [ADDR_W-1:0]   head_clamped;
  logic                rejected;
  logic                gap_ok;
  logic                over_end;
  logic                guard_done;
  logic                iter_fits;
  logic                iter_marker;
  logic                rel_wrap;
  logic                rel_ok;

  always_comb begin
    size_eff     = (ring_size > RING_A) ? RING_A : ring_size;
    need         = {1'b0, req} + NEED_W'(PREFIX_BYTES);
    tail_need    = {2'b00, tail} + {1'b0, need};
    head_adv     = {2'b00, head} + SUM_W'(PREFIX_BYTES) + {2'b00, mem_rdata};
    head_clamped = (head_adv > SUM_W'(RING_BYTES)) ? RING_A : head_adv[ADDR_W-1:0];
    rejected     = (req == '0) || (need > {1'b0, size_eff});
    gap_ok       = (head >= tail) && ({1'b0, head - tail} >= need);
    over_end     = tail_need > {2'b00, size_eff};
    guard_done   = guard == GUARD_END;
    if (wrap) begin
      iter_fits = gap_ok;
    end else if (over_end) begin
      iter_fits = {1'b0, head} >= need;
    end else begin
      iter_fits = 1'b1;
    end
    iter_marker = !guard_done && !wrap && over_end;
    rel_wrap    = wrap && (mem_rdata == '0);
    rel_ok      = !rel_wrap && (mem_rdata != '0);
  end

  always_comb begin
    mem_wr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = clr_addr;
      end
      S_ITER: begin
        mem_wr.we   = iter_marker;
        mem_wr.addr = tail;
      end
      S_REL_CHK: begin
        mem_wr.we   = rel_ok;
        mem_wr.addr = head;
      end
      S_PLACE: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = tail;
        mem_wr.data = req;
      end
      default: begin
        mem_wr = '0;
      end
    endcase
  end

  assign mem_raddr = (state == S_REL_RD) ? head : '0;
  assign in_ready  = state == S_IDLE;
  assign res_push  = (state == S_FINISH) && res_room;

  always_comb begin
    res_data.status         = res_status;
    res_data.payload_offset = res_offset;
    res_data.evicted_count  = evicted;
    res_data.is_wrapped     = wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      ring_size     <= RING_A;
      head          <= '0;
      tail          <= '0;
      wrap          <= 1'b0;
      clr_addr      <= '0;
      place_pending <= 1'b0;
    end else if (cfg_we) begin
      state         <= S_CLEAR;
      ring_size     <= cfg_wdata;
      head          <= '0;
      tail          <= '0;
      wrap          <= 1'b0;
      clr_addr      <= '0;
      place_pending <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLEAR_LAST) begin
            state         <= place_pending ? S_PLACE : S_IDLE;
            place_pending <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            action  <= in_data.action;
            req     <= in_data.request_bytes;
            guard   <= '0;
            evicted <= '0;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_offset <= '0;
          if (action == ACT_FREE) begin
            state <= S_REL_RD;
          end else if (rejected) begin
            res_status <= ST_REJECTED;
            state      <= S_FINISH;
          end else begin
            state <= S_ITER;
          end
        end
        S_ITER: begin
          if (guard_done) begin
            head          <= '0;
            tail          <= '0;
            wrap          <= 1'b0;
            clr_addr      <= '0;
            place_pending <= 1'b1;
            state         <= S_CLEAR;
          end else begin
            guard <= guard + 1'b1;
            if (iter_marker) begin
              tail <= '0;
              wrap <= 1'b1;
            end
            state <= iter_fits ? S_PLACE : S_REL_RD;
          end
        end
        S_REL_RD: begin
          state <= S_REL_CHK;
        end
        S_REL_CHK: begin
          if (rel_wrap) begin
            head <= '0;
            wrap <= 1'b0;
          end else if (action == ACT_FREE) begin
            if (rel_ok) begin
              head <= head_clamped;
            end
            res_status <= rel_ok ? ST_FREED : ST_NOTHING;
            state      <= S_FINISH;
          end else begin
            if (rel_ok) begin
              head    <= head_clamped;
              evicted <= evicted + 1'b1;
            end
            state <= S_ITER;
          end
        end
        S_PLACE: begin
          tail       <= tail_need[ADDR_W-1:0];
          res_offset <= tail + ADDR_W'(PREFIX_BYTES);
          res_status <= ST_GRANTED;
          state      <= S_FINISH;
        end
        S_FINISH: begin
          if (res_room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/ring_chunk_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring chunk allocator
// Keeps a byte ring as a queue of variable-length chunks with a length table
// in RAM, granting, evicting and freeing chunks on request.
//
//   Channel  Signals                         Direction  Contents
//   in       in_valid, in_ready, in_data     input      action, request_bytes
//   out      out_valid, out_ready, out_data  output     status, offset,
//                                                       evictions, wrap flag
//   cfg      cfg_we, cfg_wdata               input      ring_size
//
// A free reads the length word at head, then checks it and releases the
// oldest chunk, checking again at a wrap marker. An allocate is decided,
// then each iteration places the chunk or reads and releases the oldest
// one, checking again each time an eviction meets a wrap marker; a rejected
// request goes straight to its result. in_ready rises in the cycle after the
// result is pushed. Reset and every ring_size write start a clearing pass of
// the table, during which in_ready is low. A stalled result is held in the
// output register while the next transaction is accepted and processed.
// ----------------------------------------------------------------------------
module ring_chunk_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rca_pkg::ADDR_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rca_pkg::rca_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rca_pkg::rca_out_t          out_data
);

  import rca_pkg::*;

  rca_wr_t           mem_wr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [LEN_W-1:0]  mem_rdata;
  logic              res_push;
  logic              res_room;
  rca_out_t          res_data;

  rca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_room  (res_room),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rca_ram #(
    .WIDTH (LEN_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_wr.we),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rca_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .room      (res_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/tb_ring_chunk_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring chunk allocator testbench
// Sends allocate and free transactions over the valid/ready input channel in
// bursts with random gaps, while the result channel stalls on its own random
// pattern. A behavioral copy of the ring tracks head, tail, wrap flag and the
// length words. It computes the expected result of every accepted request.
// Each result transaction is checked against those expectations, field by
// field. Directed tests cover the extremes first. Random traffic over several
// ring sizes follows.
// ----------------------------------------------------------------------------
module tb_ring_chunk_allocator;
  import rca_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE} ready_mode_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  rca_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rca_out_t          out_data;

  int unsigned      ring_size_reg;
  int unsigned      head_pos;
  int unsigned      tail_pos;
  bit               ring_wrapped;
  logic [LEN_W-1:0] chunk_len [0:RING_BYTES];

  rca_out_t    awaited_results [$];
  int          errors      = 0;
  int          burst_left  = 0;
  int          hold_cycles = 0;
  int          idle_cycles = 0;
  int          mode_left   = 0;
  ready_mode_t ready_mode  = RDY_ALWAYS;

  ring_chunk_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic void empty_ring();
    head_pos     = 0;
    tail_pos     = 0;
    ring_wrapped = 1'b0;
    for (int i = 0; i <= RING_BYTES; i++) chunk_len[i] = '0;
  endfunction

  function automatic int unsigned len_at(int unsigned pos);
    return (pos <= RING_BYTES) ? chunk_len[pos] : 0;
  endfunction

  // Releases the oldest chunk, jumping back to offset 0 at a wrap marker.
  function automatic bit drop_oldest();
    int unsigned len;
    len = len_at(head_pos);
    if (ring_wrapped && len == 0) begin
      head_pos     = 0;
      len          = len_at(0);
      ring_wrapped = 1'b0;
    end
    if (len == 0) return 1'b0;
    chunk_len[head_pos] = '0;
    head_pos += PREFIX_BYTES + len;
    if (head_pos > RING_BYTES) head_pos = RING_BYTES;
    return 1'b1;
  endfunction

  function automatic rca_out_t next_allocator_result(rca_in_t item);
    rca_out_t    res;
    int unsigned size;
    int unsigned need;
    int unsigned evicted;
    int unsigned guard;
    bit          fits;
    res     = '0;
    evicted = 0;
    size    = (ring_size_reg > RING_BYTES) ? RING_BYTES : ring_size_reg;
    if (item.action == ACT_FREE) begin
      res.status = drop_oldest() ? ST_FREED : ST_NOTHING;
    end else begin
      need = PREFIX_BYTES + item.request_bytes;
      if (item.request_bytes == 0 || need > size) begin
        res.status = ST_REJECTED;
      end else begin
        fits  = 1'b0;
        guard = 0;
        while (!fits && guard < GUARD_LIMIT) begin
          fits = 1'b1;
          if (ring_wrapped) begin
            fits = head_pos >= tail_pos && head_pos - tail_pos >= need;
          end else if (tail_pos + need > size) begin
            fits               = head_pos >= need;
            chunk_len[tail_pos] = '0;
            tail_pos           = 0;
            ring_wrapped       = 1'b1;
          end
          if (!fits && drop_oldest()) evicted++;
          guard++;
        end
        if (!fits) empty_ring();
        chunk_len[tail_pos] = item.request_bytes;
        res.payload_offset  = ADDR_W'(tail_pos + PREFIX_BYTES);
        tail_pos += need;
        res.status = ST_GRANTED;
      end
    end
    res.evicted_count = EVICT_W'(evicted);
    res.is_wrapped    = ring_wrapped;
    return res;
  endfunction

  task automatic send_item(input logic act, input logic [REQ_W-1:0] req);
    rca_in_t item;
    int      gap;
    item.action        = act;
    item.request_bytes = req;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.insert(awaited_results.size(), next_allocator_result(item));
    burst_left--;
  endtask

  // Mostly small allocations, some up to the full ring, frees, and raw noise.
  task automatic send_random_item();
    int unsigned size;
    int unsigned top;
    int unsigned pick;
    size = (ring_size_reg > RING_BYTES) ? RING_BYTES : ring_size_reg;
    top  = (size > PREFIX_BYTES) ? size - PREFIX_BYTES : 1;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_item(ACT_FREE, REQ_W'($urandom));
    end else if (pick < 42) begin
      send_item(ACT_ALLOC, REQ_W'($urandom));
    end else begin
      if (top > 48 && $urandom_range(0, 4) != 0) top = 48;
      send_item(ACT_ALLOC, REQ_W'($urandom_range(1, top)));
    end
  endtask

  task automatic write_ring_size(input logic [ADDR_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_size_reg = value;
    empty_ring();
    burst_left = 0;
  endtask

  task automatic test_default_ring();
    send_item(ACT_ALLOC, 13'd0);
    send_item(ACT_ALLOC, 13'd8191);
    send_item(ACT_ALLOC, 13'd4093);
    send_item(ACT_ALLOC, 13'd4092);
    send_item(ACT_FREE, 13'd0);
    send_item(ACT_FREE, 13'd8191);
    send_item(ACT_ALLOC, 13'd1);
    send_item(ACT_ALLOC, 13'd4092);
    send_item(ACT_FREE, 13'd0);
    send_item(ACT_FREE, 13'd0);
  endtask

  task automatic test_ring_size_extremes();
    write_ring_size(13'd4);
    send_item(ACT_ALLOC, 13'd1);
    send_item(ACT_FREE, 13'd0);
    write_ring_size(13'd5);
    send_item(ACT_ALLOC, 13'd1);
    send_item(ACT_ALLOC, 13'd1);
    send_item(ACT_FREE, 13'd0);
    send_item(ACT_FREE, 13'd0);
    write_ring_size(13'd8191);
    send_item(ACT_ALLOC, 13'd4092);
    send_item(ACT_ALLOC, 13'd4093);
    write_ring_size(13'd0);
    send_item(ACT_ALLOC, 13'd1);
  endtask

  // The third allocation wraps; the frees then walk across the wrap marker.
  task automatic test_wrap_marker();
    write_ring_size(13'd64);
    repeat (3) send_item(ACT_ALLOC, 13'd20);
    repeat (3) send_item(ACT_FREE, 13'd0);
  endtask

  task automatic test_output_backpressure();
    write_ring_size(13'd200);
    hold_cycles = 400;
    repeat (24) send_random_item();
  endtask

  task automatic test_random_traffic();
    int unsigned size;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       size = $urandom_range(5, 40);
        1:       size = $urandom_range(41, 400);
        2:       size = RING_BYTES;
        3:       size = $urandom_range(RING_BYTES + 1, 8191);
        default: size = $urandom_range(5, RING_BYTES);
      endcase
      write_ring_size(ADDR_W'(size));
      repeat (80) send_random_item();
    end
  endtask

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(5, 60);
    end
    mode_left--;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:    out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    rca_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction with status %0d", out_data.status);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.payload_offset !== want.payload_offset) begin
          $error("payload_offset: expected %0d, actual %0d",
                 want.payload_offset, out_data.payload_offset);
          errors++;
        end
        if (out_data.evicted_count !== want.evicted_count) begin
          $error("evicted_count: expected %0d, actual %0d",
                 want.evicted_count, out_data.evicted_count);
          errors++;
        end
        if (out_data.is_wrapped !== want.is_wrapped) begin
          $error("is_wrapped: expected %0d, actual %0d",
                 want.is_wrapped, out_data.is_wrapped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    ring_size_reg = RING_BYTES;
    empty_ring();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_default_ring();
    test_ring_size_extremes();
    test_wrap_marker();
    test_output_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
